>>> rtl/rau_pkg.sv
// shared types, codes and command/status bundles of the rational arithmetic unit
`default_nettype none

package rau_pkg;

    localparam int WORD_BITS = 32;
    localparam int DEN_BITS  = WORD_BITS - 1;
    localparam int CNT_BITS  = $clog2(WORD_BITS + 1);
    localparam int SH_BITS   = $clog2(WORD_BITS);

    localparam logic [2:0] OP_NORM = 3'd0;
    localparam logic [2:0] OP_ADD  = 3'd1;
    localparam logic [2:0] OP_SUB  = 3'd2;
    localparam logic [2:0] OP_MUL  = 3'd3;
    localparam logic [2:0] OP_DIV  = 3'd4;
    localparam logic [2:0] OP_LT   = 3'd5;
    localparam logic [2:0] OP_EQ   = 3'd6;
    localparam logic [2:0] OP_NONE = 3'd7;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZDEN = 2'd1;
    localparam logic [1:0] ST_DIVZ = 2'd2;

    typedef enum logic [1:0] {
        SRC_A = 2'd0,
        SRC_B = 2'd1,
        SRC_R = 2'd2
    } src_t;

    typedef enum logic [2:0] {
        RES_NORM  = 3'd0,
        RES_BAD   = 3'd1,
        RES_DIV0  = 3'd2,
        RES_TRUTH = 3'd3,
        RES_ZERO  = 3'd4
    } res_sel_t;

    typedef struct packed {
        logic [2:0]         opcode;
        logic signed [31:0] a_num;
        logic signed [31:0] a_den;
        logic signed [31:0] b_num;
        logic signed [31:0] b_den;
    } rau_in_t;

    typedef struct packed {
        logic signed [31:0] res_num;
        logic [30:0]        res_den;
        logic               truth;
        logic [1:0]         status;
    } rau_out_t;

    typedef struct packed {
        logic       capture;
        logic       nload;
        src_t       src;
        logic       ncheck;
        logic       gcd_step;
        logic       gcd_fin;
        logic       div_start;
        logic       div_sel_den;
        logic       qn_store;
        logic       nfin;
        logic       store_a;
        logic       store_b;
        logic       mul_en;
        logic [1:0] mul_step;
        logic       comb;
        logic       out_load;
        res_sel_t   res_sel;
    } rau_cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       nd_zero;
        logic       nn_zero;
        logic       gcd_done;
        logic       div_busy;
        logic       a_ok;
        logic       nres_ok;
        logic       nres_num_zero;
    } rau_stat_t;

endpackage

`default_nettype wire

>>> rtl/rau_datapath.sv
// datapath: operand registers, binary gcd, serial divider, multiplier, result register
`default_nettype none

module rau_datapath (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire rau_pkg::rau_in_t   in_data,
    input  wire rau_pkg::rau_cmd_t  cmd,
    output rau_pkg::rau_stat_t      stat,
    output rau_pkg::rau_out_t       out_data
);
    import rau_pkg::*;

    logic [2:0]                  op_reg;
    logic signed [WORD_BITS-1:0] an_in_reg, ad_in_reg, bn_in_reg, bd_in_reg;
    logic signed [WORD_BITS-1:0] nin_n_reg, nin_d_reg;
    logic [WORD_BITS-1:0]        u_reg, v_reg, mn_reg, md_reg, g_reg, qn_reg;
    logic [SH_BITS-1:0]          k_reg;
    logic                        neg_reg;
    logic [WORD_BITS-1:0]        rem_reg, quo_reg;
    logic [CNT_BITS-1:0]         dcnt_reg;
    logic signed [WORD_BITS-1:0] nres_num_reg;
    logic [DEN_BITS-1:0]         nres_den_reg;
    logic                        nres_ok_reg;
    logic signed [WORD_BITS-1:0] an_reg, bn_reg;
    logic [DEN_BITS-1:0]         ad_reg, bd_reg;
    logic                        aok_reg;
    logic signed [2*WORD_BITS-1:0] p0_reg, p1_reg, p2_reg;
    logic [WORD_BITS-1:0]        rn_reg, rd_reg;
    rau_out_t                    out_reg;

    logic [WORD_BITS-1:0]          mag_n, mag_d, rs_sub;
    logic [WORD_BITS:0]            rs;
    logic signed [WORD_BITS-1:0]   ma, mb, ad_ext, bd_ext;
    logic signed [2*WORD_BITS-1:0] prod;
    logic                          truth;
    rau_out_t                      res_word;

    assign mag_n  = nin_n_reg[WORD_BITS-1] ? (WORD_BITS'(0) - nin_n_reg) : nin_n_reg;
    assign mag_d  = nin_d_reg[WORD_BITS-1] ? (WORD_BITS'(0) - nin_d_reg) : nin_d_reg;
    assign rs     = {rem_reg, quo_reg[WORD_BITS-1]};
    assign rs_sub = WORD_BITS'(rs - {1'b0, g_reg});
    assign ad_ext = $signed({1'b0, ad_reg});
    assign bd_ext = $signed({1'b0, bd_reg});

    // shared multiplier operand choice per opcode and step
    always_comb
    begin
        ma = an_reg;
        mb = bd_ext;
        unique case (cmd.mul_step)
            2'd0:
            begin
                ma = an_reg;
                mb = (op_reg == OP_MUL) ? bn_reg : bd_ext;
            end
            2'd1:
            begin
                if (op_reg == OP_MUL)
                begin
                    ma = ad_ext;
                    mb = bd_ext;
                end
                else if (op_reg == OP_DIV)
                begin
                    ma = ad_ext;
                    mb = bn_reg;
                end
                else
                begin
                    ma = bn_reg;
                    mb = ad_ext;
                end
            end
            default:
            begin
                ma = ad_ext;
                mb = bd_ext;
            end
        endcase
    end

    assign prod = ma * mb;

    assign truth = (op_reg == OP_LT) ? (p0_reg < p1_reg)
                                     : ((an_reg == bn_reg) && (ad_reg == bd_reg));

    always_comb
    begin
        res_word.res_num = '0;
        res_word.res_den = DEN_BITS'(1);
        res_word.truth   = 1'b0;
        res_word.status  = ST_OK;
        unique case (cmd.res_sel)
            RES_NORM:
            begin
                if (nres_ok_reg)
                begin
                    res_word.res_num = nres_num_reg;
                    res_word.res_den = nres_den_reg;
                end
                else
                begin
                    res_word.status = ST_ZDEN;
                end
            end
            RES_BAD:   res_word.status = ST_ZDEN;
            RES_DIV0:  res_word.status = ST_DIVZ;
            RES_TRUTH: res_word.truth  = truth;
            RES_ZERO:  res_word.status = ST_OK;
            default:   res_word.status = ST_OK;
        endcase
    end

    // control counter of the serial divider
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dcnt_reg <= '0;
        end
        else if (cmd.div_start)
        begin
            dcnt_reg <= CNT_BITS'(WORD_BITS);
        end
        else if (dcnt_reg != '0)
        begin
            dcnt_reg <= dcnt_reg - CNT_BITS'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg    <= in_data.opcode;
            an_in_reg <= in_data.a_num;
            ad_in_reg <= in_data.a_den;
            bn_in_reg <= in_data.b_num;
            bd_in_reg <= in_data.b_den;
        end

        if (cmd.nload)
        begin
            unique case (cmd.src)
                SRC_A:
                begin
                    nin_n_reg <= an_in_reg;
                    nin_d_reg <= ad_in_reg;
                end
                SRC_B:
                begin
                    nin_n_reg <= bn_in_reg;
                    nin_d_reg <= bd_in_reg;
                end
                default:
                begin
                    nin_n_reg <= $signed(rn_reg);
                    nin_d_reg <= $signed(rd_reg);
                end
            endcase
        end

        if (cmd.ncheck)
        begin
            nres_num_reg <= '0;
            nres_den_reg <= DEN_BITS'(1);
            nres_ok_reg  <= (nin_d_reg != '0);
            u_reg        <= mag_n;
            v_reg        <= mag_d;
            mn_reg       <= mag_n;
            md_reg       <= mag_d;
            k_reg        <= '0;
            neg_reg      <= nin_n_reg[WORD_BITS-1] ^ nin_d_reg[WORD_BITS-1];
        end

        // binary gcd, one step a cycle
        if (cmd.gcd_step)
        begin
            priority if (!u_reg[0] && !v_reg[0])
            begin
                u_reg <= u_reg >> 1;
                v_reg <= v_reg >> 1;
                k_reg <= k_reg + SH_BITS'(1);
            end
            else if (!u_reg[0])
            begin
                u_reg <= u_reg >> 1;
            end
            else if (!v_reg[0])
            begin
                v_reg <= v_reg >> 1;
            end
            else if (u_reg >= v_reg)
            begin
                u_reg <= u_reg - v_reg;
            end
            else
            begin
                v_reg <= v_reg - u_reg;
            end
        end

        if (cmd.gcd_fin)
        begin
            g_reg <= v_reg << k_reg;
        end

        // restoring divider, one quotient bit a cycle
        if (cmd.div_start)
        begin
            rem_reg <= '0;
            quo_reg <= cmd.div_sel_den ? md_reg : mn_reg;
        end
        else if (dcnt_reg != '0)
        begin
            if (rs >= {1'b0, g_reg})
            begin
                rem_reg <= rs_sub;
                quo_reg <= {quo_reg[WORD_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rs[WORD_BITS-1:0];
                quo_reg <= {quo_reg[WORD_BITS-2:0], 1'b0};
            end
        end

        if (cmd.qn_store)
        begin
            qn_reg <= quo_reg;
        end

        if (cmd.nfin)
        begin
            if (quo_reg[WORD_BITS-1])
            begin
                nres_ok_reg  <= 1'b0;
                nres_num_reg <= '0;
                nres_den_reg <= DEN_BITS'(1);
            end
            else
            begin
                nres_ok_reg  <= 1'b1;
                nres_num_reg <= neg_reg ? $signed(WORD_BITS'(0) - qn_reg) : $signed(qn_reg);
                nres_den_reg <= quo_reg[DEN_BITS-1:0];
            end
        end

        if (cmd.store_a)
        begin
            an_reg  <= nres_num_reg;
            ad_reg  <= nres_den_reg;
            aok_reg <= nres_ok_reg;
        end

        if (cmd.store_b)
        begin
            bn_reg <= nres_num_reg;
            bd_reg <= nres_den_reg;
        end

        if (cmd.mul_en)
        begin
            unique case (cmd.mul_step)
                2'd0:    p0_reg <= prod;
                2'd1:    p1_reg <= prod;
                default: p2_reg <= prod;
            endcase
        end

        if (cmd.comb)
        begin
            unique case (op_reg)
                OP_ADD:
                begin
                    rn_reg <= p0_reg[WORD_BITS-1:0] + p1_reg[WORD_BITS-1:0];
                    rd_reg <= p2_reg[WORD_BITS-1:0];
                end
                OP_SUB:
                begin
                    rn_reg <= p0_reg[WORD_BITS-1:0] - p1_reg[WORD_BITS-1:0];
                    rd_reg <= p2_reg[WORD_BITS-1:0];
                end
                default:
                begin
                    rn_reg <= p0_reg[WORD_BITS-1:0];
                    rd_reg <= p1_reg[WORD_BITS-1:0];
                end
            endcase
        end

        if (cmd.out_load)
        begin
            out_reg <= res_word;
        end
    end

    assign stat.op            = op_reg;
    assign stat.nd_zero       = (nin_d_reg == '0);
    assign stat.nn_zero       = (nin_n_reg == '0);
    assign stat.gcd_done      = (u_reg == '0);
    assign stat.div_busy      = (dcnt_reg != '0);
    assign stat.a_ok          = aok_reg;
    assign stat.nres_ok       = nres_ok_reg;
    assign stat.nres_num_zero = (nres_num_reg == '0);

    assign out_data = out_reg;

endmodule

`default_nettype wire

>>> rtl/rau_ctrl.sv
// controller: sequences normalization, multiply and result steps for one word
`default_nettype none

module rau_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    output logic                     out_valid,
    input  wire logic                out_ready,
    input  wire rau_pkg::rau_stat_t  stat,
    output rau_pkg::rau_cmd_t        cmd
);
    import rau_pkg::*;

    typedef enum logic [16:0] {
        S_IDLE    = 17'h00001,
        S_DISP    = 17'h00002,
        S_LD_A    = 17'h00004,
        S_LD_B    = 17'h00008,
        S_LD_R    = 17'h00010,
        S_NCHK    = 17'h00020,
        S_GCD     = 17'h00040,
        S_DIVN_GO = 17'h00080,
        S_DIVN_W  = 17'h00100,
        S_DIVD_GO = 17'h00200,
        S_DIVD_W  = 17'h00400,
        S_NEND    = 17'h00800,
        S_MUL0    = 17'h01000,
        S_MUL1    = 17'h02000,
        S_MUL2    = 17'h04000,
        S_COMB    = 17'h08000,
        S_OUT     = 17'h10000
    } state_t;

    typedef enum logic [1:0] {
        PH_A = 2'd0,
        PH_B = 2'd1,
        PH_R = 2'd2
    } phase_t;

    state_t   state_reg, state_next;
    phase_t   phase_reg, phase_next;
    res_sel_t res_sel_reg, res_sel_next;
    logic     out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        res_sel_next = res_sel_reg;
        cmd          = '0;
        cmd.res_sel  = res_sel_reg;
        in_ready     = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DISP;
                end
            end
            S_DISP:
            begin
                if (stat.op == OP_NONE)
                begin
                    res_sel_next = RES_ZERO;
                    state_next   = S_OUT;
                end
                else
                begin
                    state_next = S_LD_A;
                end
            end
            S_LD_A:
            begin
                cmd.nload  = 1'b1;
                cmd.src    = SRC_A;
                phase_next = PH_A;
                state_next = S_NCHK;
            end
            S_LD_B:
            begin
                cmd.nload  = 1'b1;
                cmd.src    = SRC_B;
                phase_next = PH_B;
                state_next = S_NCHK;
            end
            S_LD_R:
            begin
                cmd.nload  = 1'b1;
                cmd.src    = SRC_R;
                phase_next = PH_R;
                state_next = S_NCHK;
            end
            S_NCHK:
            begin
                cmd.ncheck = 1'b1;
                state_next = (stat.nd_zero || stat.nn_zero) ? S_NEND : S_GCD;
            end
            S_GCD:
            begin
                if (stat.gcd_done)
                begin
                    cmd.gcd_fin = 1'b1;
                    state_next  = S_DIVN_GO;
                end
                else
                begin
                    cmd.gcd_step = 1'b1;
                end
            end
            S_DIVN_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIVN_W;
            end
            S_DIVN_W:
            begin
                if (!stat.div_busy)
                begin
                    cmd.qn_store = 1'b1;
                    state_next   = S_DIVD_GO;
                end
            end
            S_DIVD_GO:
            begin
                cmd.div_start   = 1'b1;
                cmd.div_sel_den = 1'b1;
                state_next      = S_DIVD_W;
            end
            S_DIVD_W:
            begin
                if (!stat.div_busy)
                begin
                    cmd.nfin   = 1'b1;
                    state_next = S_NEND;
                end
            end
            S_NEND:
            begin
                unique case (phase_reg)
                    PH_A:
                    begin
                        cmd.store_a = 1'b1;
                        if (stat.op == OP_NORM)
                        begin
                            res_sel_next = RES_NORM;
                            state_next   = S_OUT;
                        end
                        else
                        begin
                            state_next = S_LD_B;
                        end
                    end
                    PH_B:
                    begin
                        cmd.store_b = 1'b1;
                        priority if (!stat.a_ok || !stat.nres_ok)
                        begin
                            res_sel_next = RES_BAD;
                            state_next   = S_OUT;
                        end
                        else if (stat.op == OP_EQ)
                        begin
                            res_sel_next = RES_TRUTH;
                            state_next   = S_OUT;
                        end
                        else if (stat.op == OP_DIV && stat.nres_num_zero)
                        begin
                            res_sel_next = RES_DIV0;
                            state_next   = S_OUT;
                        end
                        else
                        begin
                            state_next = S_MUL0;
                        end
                    end
                    default:
                    begin
                        res_sel_next = RES_NORM;
                        state_next   = S_OUT;
                    end
                endcase
            end
            S_MUL0:
            begin
                cmd.mul_en   = 1'b1;
                cmd.mul_step = 2'd0;
                state_next   = S_MUL1;
            end
            S_MUL1:
            begin
                cmd.mul_en   = 1'b1;
                cmd.mul_step = 2'd1;
                state_next   = (stat.op == OP_ADD || stat.op == OP_SUB) ? S_MUL2 : S_COMB;
            end
            S_MUL2:
            begin
                cmd.mul_en   = 1'b1;
                cmd.mul_step = 2'd2;
                state_next   = S_COMB;
            end
            S_COMB:
            begin
                cmd.comb = 1'b1;
                if (stat.op == OP_LT)
                begin
                    res_sel_next = RES_TRUTH;
                    state_next   = S_OUT;
                end
                else
                begin
                    state_next = S_LD_R;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_A;
            res_sel_reg   <= RES_ZERO;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            res_sel_reg   <= res_sel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten while held");
    a_rise_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("result raised outside output state");
    a_div_runs: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> stat.div_busy)
        else $error("divider did not start");
    a_gcd_step: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.gcd_step |-> !stat.gcd_done)
        else $error("gcd stepped after completion");
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second word taken while busy");
`endif

endmodule

`default_nettype wire

>>> rtl/rational_arith_unit.sv
// top level of the rational arithmetic unit: controller plus datapath
`default_nettype none

// rational arithmetic unit
// input channel in_valid/in_ready/in_data carries one word: opcode and two
// signed fractions a_num/a_den and b_num/b_den. output channel
// out_valid/out_ready/out_data carries one word per input word: the reduced
// fraction res_num/res_den, the compare bit truth and a status code.
// each operand is reduced by a binary gcd loop (one step a cycle) and then
// divided by the gcd on a shared restoring divider (two quotients per
// reduction). arithmetic results go through the same reduction a second time
// after the multiplier, which forms up to three products, one a cycle.
// one word is in work at a time: the unit takes no new word until the
// result of the last one is in the output register.
// the result sits in an output register: the unit takes the next word while
// an earlier result waits, and stalls only if a new result is ready before
// the receiver has taken the old one.
// reset clears the controller and output valid; no result is pending after it.

module rational_arith_unit (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire rau_pkg::rau_in_t  in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output rau_pkg::rau_out_t      out_data
);
    import rau_pkg::*;

    // command and status bundles between sequencer and datapath
    rau_cmd_t  cmd;
    rau_stat_t stat;

    rau_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // operand capture, gcd, divider, multiplier and result register
    rau_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .cmd      (cmd),
        .stat     (stat),
        .out_data (out_data)
    );

endmodule

`default_nettype wire

>>> verif/tb_rational_arith_unit.sv
// self-checking testbench of the rational arithmetic unit: directed and random words
`timescale 1ns / 1ps

module tb_rational_arith_unit;
    import rau_pkg::*;

    // scoreboard: predicts the result word of each accepted input word and
    // checks result words against the oldest prediction
    class frac_scoreboard;
        rau_out_t pending_results[$];
        int       mismatch_count;

        // reduce n/d on 64-bit sign-extended words; zero on a bad denominator
        static function bit reduce_frac(input longint n, input longint d,
                                        output logic [31:0] rn, output logic [30:0] rd);
            longint unsigned mn, md, p, q, t;
            bit neg;
            rn = '0;
            rd = 31'd1;
            if (d == 0) return 1'b0;
            if (n == 0) return 1'b1;
            mn = (n < 0) ? longint'(-n) : n;
            md = (d < 0) ? longint'(-d) : d;
            p = mn;
            q = md;
            while (q != 0)
            begin
                t = p % q;
                p = q;
                q = t;
            end
            mn = mn / p;
            md = md / p;
            // the denominator must fit the positive half of the word
            if (md >= 64'h8000_0000) return 1'b0;
            neg = (n < 0) ^ (d < 0);
            rn = neg ? (32'd0 - mn[31:0]) : mn[31:0];
            rd = md[30:0];
            return 1'b1;
        endfunction

        function void note_input(rau_in_t w);
            rau_out_t r;
            logic [31:0] an, bn, n, d;
            logic [30:0] ad, bd;
            bit oka, okb;
            longint l, m;
            r = '{res_num: 0, res_den: 31'd1, truth: 1'b0, status: ST_OK};
            oka = reduce_frac(w.a_num, w.a_den, an, ad);
            okb = reduce_frac(w.b_num, w.b_den, bn, bd);
            if (w.opcode == OP_NORM)
            begin
                if (oka)
                begin
                    r.res_num = an;
                    r.res_den = ad;
                end
                else r.status = ST_ZDEN;
            end
            else if (w.opcode != OP_NONE)
            begin
                if (!oka || !okb) r.status = ST_ZDEN;
                else if (w.opcode == OP_LT)
                begin
                    l = longint'($signed(an)) * longint'({1'b0, bd});
                    m = longint'($signed(bn)) * longint'({1'b0, ad});
                    r.truth = (l < m);
                end
                else if (w.opcode == OP_EQ) r.truth = (an == bn) && (ad == bd);
                else if (w.opcode == OP_DIV && bn == 0) r.status = ST_DIVZ;
                else
                begin
                    // all products and sums wrap to 32 bits
                    case (w.opcode)
                        OP_ADD:
                        begin
                            n = an * {1'b0, bd} + bn * {1'b0, ad};
                            d = {1'b0, ad} * {1'b0, bd};
                        end
                        OP_SUB:
                        begin
                            n = an * {1'b0, bd} - bn * {1'b0, ad};
                            d = {1'b0, ad} * {1'b0, bd};
                        end
                        OP_MUL:
                        begin
                            n = an * bn;
                            d = {1'b0, ad} * {1'b0, bd};
                        end
                        default:
                        begin
                            n = an * {1'b0, bd};
                            d = {1'b0, ad} * bn;
                        end
                    endcase
                    if (!reduce_frac(longint'($signed(n)), longint'($signed(d)),
                                     r.res_num, r.res_den))
                        r.status = ST_ZDEN;
                end
            end
            if (r.status != ST_OK)
            begin
                r.res_num = 0;
                r.res_den = 31'd1;
                r.truth = 1'b0;
            end
            pending_results.push_back(r);
        endfunction

        task report_mismatch(string what);
            $display("mismatch: %s", what);
            mismatch_count++;
        endtask

        task check_result(rau_out_t got);
            rau_out_t exp;
            if (pending_results.size() == 0)
            begin
                report_mismatch("result word with nothing pending");
                return;
            end
            exp = pending_results.pop_front();
            if (got.res_num !== exp.res_num)
                report_mismatch($sformatf("res_num %0d, wanted %0d",
                                          $signed(got.res_num), $signed(exp.res_num)));
            if (got.res_den !== exp.res_den)
                report_mismatch($sformatf("res_den %0d, wanted %0d", got.res_den, exp.res_den));
            if (got.truth !== exp.truth)
                report_mismatch($sformatf("truth %0b, wanted %0b", got.truth, exp.truth));
            if (got.status !== exp.status)
                report_mismatch($sformatf("status %0d, wanted %0d", got.status, exp.status));
        endtask
    endclass

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_ready;
    rau_in_t  in_data;
    logic     out_valid;
    logic     out_ready;
    rau_out_t out_data;

    frac_scoreboard frac_board;
    int  send_idle_pct;     // percent of cycles the sender holds back
    int  recv_stall_pct;    // percent of cycles the receiver stalls
    longint cycle_count;

    localparam longint CYCLE_LIMIT = 4_000_000;

    rational_arith_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog on cycles
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[rational_arith_unit] ERROR");
            $finish;
        end
    end

    // receiver: random stall, checks each accepted result word
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready) frac_board.check_result(out_data);
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // random operand value biased toward edge patterns and small values
    function automatic logic [31:0] pick_value();
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'(int'($urandom_range(4)) - 2);
            3, 4: return 32'(int'($urandom_range(200)) - 100);
            5: return 32'(int'($urandom_range(131070)) - 65535);
            6: return 32'h1 << $urandom_range(31);
            default: return $urandom;
        endcase
    endfunction

    // present one word and hold it until accepted; valid stays high after
    // the accept so that the next word can follow with no gap
    task send_word(logic [2:0] op, logic [31:0] an, logic [31:0] ad,
                   logic [31:0] bn, logic [31:0] bd);
        rau_in_t w;
        w = '{opcode: op, a_num: an, a_den: ad, b_num: bn, b_den: bd};
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        frac_board.note_input(w);
    endtask

    task send_random(int n);
        logic [2:0] op;
        for (int i = 0; i < n; i++)
        begin
            op = 3'($urandom_range(7));
            send_word(op, pick_value(), pick_value(), pick_value(), pick_value());
        end
    endtask

    task wait_drained();
        in_valid <= 1'b0;
        while (frac_board.pending_results.size() != 0) @(posedge clk);
    endtask

    initial
    begin
        frac_board     = new();
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_data        = '0;
        out_ready      = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        cycle_count    = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: every opcode, field extremes, zero denominators,
        // division by zero, wrapped denominators and numerator overflow
        send_word(OP_NORM, 32'd6, -32'sd4, 0, 0);
        send_word(OP_NORM, 0, 32'd5, 0, 0);
        send_word(OP_NORM, 32'd3, 0, 32'd1, 32'd1);
        send_word(OP_NORM, 32'h8000_0000, 32'hffff_ffff, 0, 0);
        send_word(OP_NORM, 32'd1, 32'h8000_0000, 0, 0);
        send_word(OP_NORM, 32'h7fff_ffff, 32'h7fff_ffff, 32'hffff_ffff, 0);
        send_word(OP_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
        send_word(OP_ADD, 32'd1, 32'd65536, 32'd1, 32'd65536);
        send_word(OP_ADD, 32'd1, 32'd2, 32'd1, 0);
        send_word(OP_SUB, 32'd1, 32'd2, 32'd1, 32'd2);
        send_word(OP_SUB, 32'h7fff_ffff, 32'd1, 32'hffff_ffff, 32'd1);
        send_word(OP_MUL, -32'sd3, 32'd4, 32'd4, -32'sd3);
        send_word(OP_MUL, 32'h7fff_ffff, 32'd1, 32'h7fff_ffff, 32'd1);
        send_word(OP_MUL, 32'd1, 32'd46341, 32'd1, 32'd46341);
        send_word(OP_DIV, 32'd1, 32'd2, 0, 32'd7);
        send_word(OP_DIV, 32'd3, 32'd5, -32'sd7, 32'd2);
        send_word(OP_DIV, 32'd1, 32'd3, 32'd1, 0);
        send_word(OP_LT, -32'sd1, 32'd2, 32'd1, 32'd3);
        send_word(OP_LT, 32'h7fff_ffff, 32'd1, 32'h8000_0000, 32'd1);
        send_word(OP_LT, 32'd1, 32'd2, 32'd2, 32'd4);
        send_word(OP_EQ, 32'd2, 32'd4, -32'sd1, -32'sd2);
        send_word(OP_EQ, 32'd1, 32'd2, 32'd1, 32'd3);
        send_word(OP_EQ, 32'd1, 0, 32'd1, 32'd1);
        send_word(OP_NONE, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);

        send_random(400);
        // hold off until the unit has emptied
        wait_drained();
        send_idle_pct = 73;
        send_random(350);
        send_idle_pct  = 0;
        recv_stall_pct = 73;
        send_random(350);
        send_idle_pct  = 14;
        recv_stall_pct = 14;
        send_random(350);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_random(100);

        wait_drained();
        repeat (500) @(posedge clk);
        if (frac_board.pending_results.size() != 0)
            frac_board.report_mismatch("results still pending at end");
        if (frac_board.mismatch_count == 0)
            $display("[rational_arith_unit] OK");
        else
            $display("[rational_arith_unit] ERROR");
        $finish;
    end
endmodule

>>> sim.f
rtl/rau_pkg.sv
rtl/rau_datapath.sv
rtl/rau_ctrl.sv
rtl/rational_arith_unit.sv
verif/tb_rational_arith_unit.sv
